// ===== rtl/separated_field_message_parser_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SEPARATED_FIELD_MESSAGE_PARSER_UNIT_MACROS_SVH
`define SEPARATED_FIELD_MESSAGE_PARSER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SFMP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");
`define SFMP_ASSERT_NEXT(lbl, pre, post) `SFMP_ASSERT(lbl, (pre) |=> (post))
`else
`define SFMP_ASSERT(lbl, prop)
`define SFMP_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== rtl/sfmp_pkg.sv =====
// ----------------------------------------------------------------------------
// sfmp_pkg
// Shared types and constants of the separated field message parser.
// ----------------------------------------------------------------------------
package sfmp_pkg;
  localparam int TOKEN_LIMIT_DEF = 16;
  localparam int PARAM_LIMIT_DEF = 8;
  localparam int HDR_TOKENS      = 5;
  localparam logic [7:0] SEP_RESET = 8'd124;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [2:0] CLS_HEADER  = 3'd0;
  localparam logic [2:0] CLS_COMMAND = 3'd1;
  localparam logic [2:0] CLS_PARAM   = 3'd2;
  localparam logic [2:0] CLS_SEP     = 3'd3;
  localparam logic [2:0] CLS_PAYLOAD = 3'd4;
  localparam logic [2:0] CLS_IGNORED = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_STRUCT    = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [2:0]  byte_class;
    logic [4:0]  token_number;
    logic        eom;
    logic [1:0]  status;
    logic [15:0] version;
    logic [7:0]  field_count;
    logic [31:0] payload_length;
    logic [63:0] time_stamp;
    logic [3:0]  param_count;
  } sfmp_rec_t;
endpackage

// ===== rtl/sfmp_if.sv =====
// ----------------------------------------------------------------------------
// sfmp_in_if / sfmp_out_if
// Valid/ready channels for input bytes and result words.
// ----------------------------------------------------------------------------
interface sfmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;
  modport source(output valid, data_byte, end_of_message, input ready);
  modport sink(input valid, data_byte, end_of_message, output ready);
endinterface

interface sfmp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_value;
  logic [2:0]  byte_class;
  logic [4:0]  token_number;
  logic        is_summary;
  logic [1:0]  status;
  logic [15:0] version;
  logic [7:0]  field_count;
  logic [31:0] payload_length;
  logic [63:0] time_stamp;
  logic [3:0]  param_count;
  logic        last_of_run;
  modport source(output valid, byte_value, byte_class, token_number, is_summary, status,
                 version, field_count, payload_length, time_stamp, param_count,
                 last_of_run, input ready);
  modport sink(input valid, byte_value, byte_class, token_number, is_summary, status,
               version, field_count, payload_length, time_stamp, param_count,
               last_of_run, output ready);
endinterface

// ===== rtl/sfmp_front.sv =====
// ----------------------------------------------------------------------------
// sfmp_front
// Tokenizer: classifies each byte, accumulates header numbers, builds summary.
// ----------------------------------------------------------------------------
module sfmp_front #(
  parameter int TOKEN_LIMIT = sfmp_pkg::TOKEN_LIMIT_DEF,
  parameter int PARAM_LIMIT = sfmp_pkg::PARAM_LIMIT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                sep_we_i,
  input  logic [7:0]          sep_data_i,
  input  logic                push_i,
  input  logic [7:0]          data_byte_i,
  input  logic                eom_i,
  output sfmp_pkg::sfmp_rec_t rec_o
);
  import sfmp_pkg::*;

  localparam int TW = $clog2(TOKEN_LIMIT + 1);
  localparam logic [1:0] PH_TOK  = 2'd0;
  localparam logic [1:0] PH_PAY  = 2'd1;
  localparam logic [1:0] PH_FAIL = 2'd2;

  logic [7:0]    sep_q;
  logic [1:0]    phase_q, phase_d;
  logic [TW-1:0] ts_q, ts_d, idx;
  logic          start_q, start_d, dact_q, dact_d, fcs_q, fcs_d;
  logic [15:0]   ver_q, ver_d;
  logic [7:0]    cnt_q, cnt_d;
  logic [31:0]   len_q, len_d, pbs_q, pbs_d, pbs_inc;
  logic [63:0]   stm_q, stm_d;
  logic [19:0]   ver_m;
  logic [11:0]   cnt_m;
  logic [35:0]   len_m;
  logic [67:0]   stm_m;
  logic [3:0]    dig;
  logic          is_sep, is_dig, ok;
  logic [2:0]    cls;
  logic [TW-1:0] pc;

  assign dig     = data_byte_i[3:0];
  assign is_dig  = data_byte_i >= 8'h30 && data_byte_i <= 8'h39;
  assign is_sep  = data_byte_i == sep_q;
  assign pbs_inc = (pbs_q == '1) ? pbs_q : pbs_q + 32'd1;
  assign ver_m   = 20'(ver_q) * 20'd10 + 20'(dig);
  assign cnt_m   = 12'(cnt_q) * 12'd10 + 12'(dig);
  assign len_m   = 36'(len_q) * 36'd10 + 36'(dig);
  assign stm_m   = 68'(stm_q) * 68'd10 + 68'(dig);

  always_comb begin
    phase_d = phase_q;
    ts_d    = ts_q;
    start_d = start_q;
    dact_d  = dact_q;
    fcs_d   = fcs_q;
    ver_d   = ver_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    stm_d   = stm_q;
    pbs_d   = pbs_q;
    cls     = CLS_IGNORED;
    idx     = '0;
    case (phase_q)
      PH_TOK: begin
        if (start_q) begin
          ts_d   = ts_q + TW'(1);
          dact_d = 1'b1;
        end
        start_d = 1'b0;
        idx     = ts_d - TW'(1);
        if (is_sep) begin
          cls     = CLS_SEP;
          start_d = 1'b1;
          pbs_d   = '0;
          if (idx == TW'(1)) begin
            fcs_d = 1'b1;
            if (cnt_q < 8'(HDR_TOKENS) || cnt_q > 8'(TOKEN_LIMIT)) phase_d = PH_FAIL;
          end
          if (phase_d == PH_TOK) begin
            if (fcs_d && 8'(ts_d) == cnt_q) phase_d = PH_PAY;
            else if (ts_d >= TW'(TOKEN_LIMIT)) phase_d = PH_FAIL;
          end
        end else begin
          cls   = (idx < TW'(4)) ? CLS_HEADER : ((idx == TW'(4)) ? CLS_COMMAND : CLS_PARAM);
          pbs_d = pbs_inc;
          if (idx < TW'(4) && dact_d) begin
            if (is_dig) begin
              case (idx[1:0])
                2'd0:    ver_d = (|ver_m[19:16]) ? '1 : ver_m[15:0];
                2'd1:    cnt_d = (|cnt_m[11:8]) ? '1 : cnt_m[7:0];
                2'd2:    len_d = (|len_m[35:32]) ? '1 : len_m[31:0];
                default: stm_d = (|stm_m[67:64]) ? '1 : stm_m[63:0];
              endcase
            end else begin
              dact_d = 1'b0;
            end
          end
        end
      end
      PH_PAY: begin
        cls   = (pbs_q < len_q) ? CLS_PAYLOAD : CLS_IGNORED;
        pbs_d = pbs_inc;
      end
      default: ;
    endcase
  end

  assign pc = ts_d - TW'(HDR_TOKENS);

  always_comb begin
    case (phase_d)
      PH_FAIL: ok = 1'b0;
      PH_TOK:  ok = fcs_d && 8'(ts_d) == cnt_d;
      default: ok = 1'b1;
    endcase
    if (ts_d < TW'(HDR_TOKENS) || 32'(pc) >= 32'(PARAM_LIMIT)) ok = 1'b0;
    rec_o.data_byte    = data_byte_i;
    rec_o.byte_class   = cls;
    rec_o.token_number = 5'(idx);
    rec_o.eom          = eom_i;
    rec_o.status       = ok ? ((len_d > pbs_d) ? ST_TRUNCATED : ST_OK) : ST_STRUCT;
    rec_o.version        = ok ? ver_d : '0;
    rec_o.field_count    = ok ? cnt_d : '0;
    rec_o.payload_length = ok ? len_d : '0;
    rec_o.time_stamp     = ok ? stm_d : '0;
    rec_o.param_count    = ok ? 4'(pc) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q   <= SEP_RESET;
      phase_q <= PH_TOK;
      ts_q    <= '0;
      start_q <= 1'b1;
      dact_q  <= 1'b1;
      fcs_q   <= 1'b0;
      ver_q   <= '0;
      cnt_q   <= '0;
      len_q   <= '0;
      stm_q   <= '0;
      pbs_q   <= '0;
    end else begin
      if (sep_we_i) sep_q <= sep_data_i;
      if (push_i) begin
        if (eom_i) begin
          phase_q <= PH_TOK;
          ts_q    <= '0;
          start_q <= 1'b1;
          dact_q  <= 1'b1;
          fcs_q   <= 1'b0;
          ver_q   <= '0;
          cnt_q   <= '0;
          len_q   <= '0;
          stm_q   <= '0;
          pbs_q   <= '0;
        end else begin
          phase_q <= phase_d;
          ts_q    <= ts_d;
          start_q <= start_d;
          dact_q  <= dact_d;
          fcs_q   <= fcs_d;
          ver_q   <= ver_d;
          cnt_q   <= cnt_d;
          len_q   <= len_d;
          stm_q   <= stm_d;
          pbs_q   <= pbs_d;
        end
      end
    end
  end
endmodule

// ===== rtl/sfmp_queue.sv =====
// ----------------------------------------------------------------------------
// sfmp_queue
// Short FIFO of classified byte records between front and back.
// ----------------------------------------------------------------------------
module sfmp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sfmp_pkg::sfmp_rec_t wdata_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output sfmp_pkg::sfmp_rec_t rdata_o
);
  import sfmp_pkg::*;

  sfmp_rec_t       mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == QCNT_W'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
      if (pop_i)  rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + QCNT_W'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - QCNT_W'(1);
    end
  end
endmodule

// ===== rtl/sfmp_back.sv =====
// ----------------------------------------------------------------------------
// sfmp_back
// Emits the byte word of each record, then the summary word on message end.
// ----------------------------------------------------------------------------
`include "separated_field_message_parser_unit_macros.svh"
module sfmp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  sfmp_pkg::sfmp_rec_t head_i,
  output logic                pop_o,
  sfmp_out_if.source          out_o
);
  import sfmp_pkg::*;

  logic sum_q, sum_d, take;

  assign take  = out_o.valid && out_o.ready;
  assign pop_o = take && (sum_q || !head_i.eom);
  assign sum_d = take ? (!sum_q && head_i.eom) : sum_q;

  always_comb begin
    out_o.valid          = head_valid_i;
    out_o.byte_value     = sum_q ? '0 : head_i.data_byte;
    out_o.byte_class     = sum_q ? CLS_HEADER : head_i.byte_class;
    out_o.token_number   = sum_q ? '0 : head_i.token_number;
    out_o.is_summary     = sum_q;
    out_o.status         = sum_q ? head_i.status : ST_OK;
    out_o.version        = sum_q ? head_i.version : '0;
    out_o.field_count    = sum_q ? head_i.field_count : '0;
    out_o.payload_length = sum_q ? head_i.payload_length : '0;
    out_o.time_stamp     = sum_q ? head_i.time_stamp : '0;
    out_o.param_count    = sum_q ? head_i.param_count : '0;
    out_o.last_of_run    = sum_q || !head_i.eom;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sum_q <= 1'b0;
    else         sum_q <= sum_d;
  end

  `SFMP_ASSERT(a_sum_has_eom, sum_q |-> (head_valid_i && head_i.eom))
  `SFMP_ASSERT_NEXT(a_eom_to_sum, take && !sum_q && head_i.eom, sum_q)
  `SFMP_ASSERT_NEXT(a_sum_done, take && sum_q, !sum_q)
endmodule

// ===== rtl/separated_field_message_parser_unit.sv =====
// ----------------------------------------------------------------------------
// separated_field_message_parser_unit
// Splits a byte stream at a separator, tags bytes, summarizes each message.
// ----------------------------------------------------------------------------
// channel   dir  handshake    payload
// in_i      in   valid/ready  data_byte, end_of_message
// out_o     out  valid/ready  byte word, or summary after an end byte
// sep_*     in   we only      separator byte
//
// One byte accepted per cycle while the 2-entry queue has room.
// One result word per cycle while out_o is ready; an end byte yields two, its byte and summary.
// Front tokenizer and back emitter stall independently through the queue.
// Reset clears message state and sets the separator to 124.
module separated_field_message_parser_unit #(
  parameter int TOKEN_LIMIT = sfmp_pkg::TOKEN_LIMIT_DEF,
  parameter int PARAM_LIMIT = sfmp_pkg::PARAM_LIMIT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       sep_we_i,
  input  logic [7:0] sep_data_i,
  sfmp_in_if.sink    in_i,
  sfmp_out_if.source out_o
);
  import sfmp_pkg::*;

  sfmp_rec_t rec, head;
  logic      full, push, pop, head_valid;

  assign in_i.ready = !full;
  assign push       = in_i.valid && !full;

  sfmp_front #(.TOKEN_LIMIT(TOKEN_LIMIT), .PARAM_LIMIT(PARAM_LIMIT)) u_front (
    .clk_i, .rst_ni, .sep_we_i, .sep_data_i,
    .push_i(push), .data_byte_i(in_i.data_byte), .eom_i(in_i.end_of_message),
    .rec_o(rec)
  );

  sfmp_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(rec), .full_o(full),
    .pop_i(pop), .valid_o(head_valid), .rdata_o(head)
  );

  sfmp_back u_back (
    .clk_i, .rst_ni, .head_valid_i(head_valid), .head_i(head), .pop_o(pop), .out_o(out_o)
  );
endmodule

// ===== sim/tb_separated_field_message_parser_unit.sv =====
// ----------------------------------------------------------------------------
// tb_separated_field_message_parser_unit
// Drives messages byte by byte, predicts every tagged byte word and each
// summary word, and compares each output word whole under random idling.
// ----------------------------------------------------------------------------
module tb_separated_field_message_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import sfmp_pkg::*;

  localparam int TOK_LIM   = TOKEN_LIMIT_DEF;
  localparam int PRM_LIM   = PARAM_LIMIT_DEF;
  localparam int MAX_CYC   = 1500000;
  localparam int N_RANDOM  = 1100;

  typedef enum logic [1:0] {PH_TOK, PH_PAY, PH_FAIL} phase_e;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic [2:0]  byte_class;
    logic [4:0]  token_number;
    logic        is_summary;
    logic [1:0]  status;
    logic [15:0] version;
    logic [7:0]  field_count;
    logic [31:0] payload_length;
    logic [63:0] time_stamp;
    logic [3:0]  param_count;
    logic        last_of_run;
  } word_t;

  typedef struct {
    logic [7:0] b;
    logic       eom;
    logic       has_exp;
    word_t      w;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic sep_we_i = 1'b0;
  logic [7:0] sep_data_i = 8'd0;

  sfmp_in_if  in_ch();
  sfmp_out_if out_ch();

  separated_field_message_parser_unit u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .sep_we_i(sep_we_i), .sep_data_i(sep_data_i),
    .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  always #6 clk_i = ~clk_i;

  // predictor state
  logic [7:0]  sep_q;
  phase_e      phase_q;
  int unsigned ntok;
  bit          tok_start, dig_on, cnt_seen;
  logic [15:0] ver_acc;
  logic [7:0]  cnt_acc;
  logic [31:0] len_acc;
  logic [63:0] stamp_acc;
  logic [31:0] pay_seen;

  word_t       exp_words[$];
  int          errors = 0;
  int          cycles = 0;
  int          n_sent = 0;
  int          rstall = 0;

  function automatic logic [63:0] acc_digit(logic [63:0] acc, int d, logic [63:0] maxv);
    if (acc > (maxv - 64'(d)) / 64'd10) return maxv;
    return acc * 64'd10 + 64'(d);
  endfunction

  task automatic clear_msg();
    phase_q = PH_TOK; ntok = 0; tok_start = 1; dig_on = 1; cnt_seen = 0;
    ver_acc = '0; cnt_acc = '0; len_acc = '0; stamp_acc = '0; pay_seen = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eom);
    word_t w, s;
    int unsigned idx;
    bit ok;
    w = '0;
    w.byte_class = CLS_IGNORED;
    if (phase_q == PH_TOK) begin
      if (tok_start) begin
        ntok++; tok_start = 0; dig_on = 1;
      end
      idx = ntok - 1;
      w.token_number = idx[4:0];
      if (b == sep_q) begin
        w.byte_class = CLS_SEP;
        tok_start = 1;
        pay_seen = '0;
        if (idx == 1) begin
          cnt_seen = 1;
          if (cnt_acc < HDR_TOKENS || cnt_acc > TOK_LIM) phase_q = PH_FAIL;
        end
        if (phase_q == PH_TOK) begin
          if (cnt_seen && ntok == cnt_acc) phase_q = PH_PAY;
          else if (ntok >= TOK_LIM) phase_q = PH_FAIL;
        end
      end else begin
        w.byte_class = idx < 4 ? CLS_HEADER : (idx == 4 ? CLS_COMMAND : CLS_PARAM);
        if (pay_seen != '1) pay_seen++;
        if (idx < 4 && dig_on) begin
          if (b >= 8'h30 && b <= 8'h39) begin
            case (idx)
              0: ver_acc = 16'(acc_digit(ver_acc, b - 8'h30, 64'hFFFF));
              1: cnt_acc = 8'(acc_digit(cnt_acc, b - 8'h30, 64'hFF));
              2: len_acc = 32'(acc_digit(len_acc, b - 8'h30, 64'hFFFF_FFFF));
              default: stamp_acc = acc_digit(stamp_acc, b - 8'h30, '1);
            endcase
          end else begin
            dig_on = 0;
          end
        end
      end
    end else if (phase_q == PH_PAY) begin
      w.byte_class = pay_seen < len_acc ? CLS_PAYLOAD : CLS_IGNORED;
      if (pay_seen != '1) pay_seen++;
    end
    w.byte_value = b;
    w.last_of_run = !eom;
    exp_words.push_back(w);
    if (eom) begin
      s = '0;
      if (phase_q == PH_FAIL) ok = 0;
      else if (phase_q == PH_TOK) ok = cnt_seen && ntok == cnt_acc;
      else ok = 1;
      if (ok && (ntok < HDR_TOKENS || ntok - HDR_TOKENS >= PRM_LIM)) ok = 0;
      s.is_summary = 1;
      s.last_of_run = 1;
      if (ok) begin
        s.status = (len_acc > 0 && len_acc > pay_seen) ? ST_TRUNCATED : ST_OK;
        s.version = ver_acc; s.field_count = cnt_acc;
        s.payload_length = len_acc; s.time_stamp = stamp_acc;
        s.param_count = 4'(ntok - HDR_TOKENS);
      end else begin
        s.status = ST_STRUCT;
      end
      exp_words.push_back(s);
      clear_msg();
    end
  endtask

  // directed table; typed expectations only for the first byte after reset
  row_t dir_rows[$];

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver side with checking
  always @(posedge clk_i) begin
    word_t got, want;
    cycles <= cycles + 1;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.byte_value, out_ch.byte_class, out_ch.token_number,
              out_ch.is_summary, out_ch.status, out_ch.version, out_ch.field_count,
              out_ch.payload_length, out_ch.time_stamp, out_ch.param_count,
              out_ch.last_of_run};
      if (exp_words.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", got);
      end else begin
        want = exp_words.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: exp %h got %h", want, got);
        end
      end
    end
    if (!rst_ni) out_ch.ready <= 1'b0;
    else if (rstall > 0) begin
      rstall <= rstall - 1; out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) rstall <= gap_len();
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eom);
    int g;
    g = gap_len();
    repeat (g) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.end_of_message <= eom;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    parse_byte(b, eom);
    n_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (exp_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_sep(input logic [7:0] v);
    sep_we_i <= 1'b1;
    sep_data_i <= v;
    @(posedge clk_i);
    sep_we_i <= 1'b0;
    sep_q = v;
  endtask

  task automatic send_num(input logic [63:0] v, input int ndig);
    logic [63:0] t;
    byte unsigned d[$];
    int n;
    t = v;
    n = 0;
    do begin
      d.push_front(8'(t % 10) + 8'h30);
      t = t / 10;
      n++;
    end while (n < ndig || (ndig == 0 && t != 0));
    foreach (d[i]) send_byte(d[i], 1'b0);
  endtask

  function automatic logic [7:0] rnd_nonsep();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == sep_q);
    return b;
  endfunction

  // well-formed message with random content and occasional corruption
  task automatic send_message();
    int fc, np, plen, avail, mode;
    mode = $urandom_range(0, 9);
    np = $urandom_range(0, PRM_LIM);
    fc = HDR_TOKENS + np;
    if (mode == 0) fc = $urandom_range(0, 25);
    plen = $urandom_range(0, 6);
    avail = (mode == 1) ? $urandom_range(0, plen) : plen + $urandom_range(0, 2);
    send_num($urandom_range(0, 65535), $urandom_range(0, 1) ? 0 : $urandom_range(1, 7));
    send_byte(sep_q, 1'b0);
    send_num(fc, 0);
    if (mode == 2) send_byte(rnd_nonsep(), 1'b0);
    send_byte(sep_q, 1'b0);
    send_num(plen, 0);
    send_byte(sep_q, 1'b0);
    if (mode == 3) send_num(64'hFFFF_FFFF_FFFF_FFFF, 21);
    else send_num({$urandom, $urandom}, 0);
    send_byte(sep_q, 1'b0);
    for (int t = HDR_TOKENS - 1; t < fc && t < 20; t++) begin
      repeat ($urandom_range(1, 3)) send_byte(rnd_nonsep(), 1'b0);
      if (t == fc - 1 && avail > 0 && $urandom_range(0, 3) == 0) begin
        repeat (avail) send_byte(rnd_nonsep(), 1'b0);
        send_byte(rnd_nonsep(), 1'b1);
        return;
      end
      send_byte(sep_q, 1'b0);
    end
    repeat (avail) send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    row_t r;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'd0;
    in_ch.end_of_message = 1'b0;
    sep_q = SEP_RESET;
    clear_msg();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: lone end byte after reset -> header byte then structure error
    r.b = 8'h35; r.eom = 1; r.has_exp = 1;
    r.w = '0; r.w.byte_value = 8'h35; r.w.byte_class = CLS_HEADER;
    dir_rows.push_back(r);
    r.has_exp = 0;
    begin
      string s;
      s = "70000|5|2|18446744073709551616|C|xy";
      foreach (s[i]) begin
        r.b = s[i]; r.eom = (i == s.len() - 1); dir_rows.push_back(r);
      end
      s = "-1|3|0|0|x|";
      foreach (s[i]) begin
        r.b = s[i]; r.eom = (i == s.len() - 1); dir_rows.push_back(r);
      end
    end
    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_exp) begin
        word_t s2;
        s2 = '0; s2.is_summary = 1; s2.status = ST_STRUCT; s2.last_of_run = 1;
        send_byte(dir_rows[i].b, dir_rows[i].eom);
        void'(exp_words.pop_back()); void'(exp_words.pop_back());
        exp_words.push_back(dir_rows[i].w);
        exp_words.push_back(s2);
      end else begin
        send_byte(dir_rows[i].b, dir_rows[i].eom);
      end
    end
    drain();

    // separator extremes, a digit separator, then random phases
    begin
      logic [7:0] seps[5];
      seps = '{8'd0, 8'd255, 8'h35, 8'h2C, SEP_RESET};
      for (int p = 0; p < 5; p++) begin
        set_sep(seps[p]);
        while (n_sent < (p + 1) * N_RANDOM / 5) begin
          if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), 1'b0);
            send_byte(8'($urandom_range(0, 255)), 1'b1);
          end else begin
            send_message();
          end
          if (p == 2 && n_sent < 700 && n_sent > 600) drain();
        end
        drain();
      end
    end
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    wait (cycles >= MAX_CYC);
    $display("Regression FAIL");
    $finish;
  end
endmodule
